### rtl/pbc_pkg.sv
// Package for the player button controller: register map, reset values,
// field widths and the shared config and state structs.
// No dependencies.
package pbc_pkg;

    // countdown width default
    localparam int COUNT_BITS_DEF = 24;

    // field widths
    localparam int SRATE_W   = 17;
    localparam int ATT_W     = 8;
    localparam int STEP_W    = 4;
    localparam int ELAPSED_W = 12;
    localparam int RELOAD_W  = SRATE_W - 1;
    localparam int S_DATA_W  = 16;
    localparam int M_DATA_W  = 16;
    localparam int ADDR_W    = 4;

    // register reset values
    localparam logic [SRATE_W-1:0] SAMPLE_RATE_RST = 17'd44100;
    localparam logic [ATT_W-1:0]   ATT_UPPER_RST   = 8'd96;
    localparam logic [ATT_W-1:0]   ATT_LOWER_RST   = 8'd3;
    localparam logic [STEP_W-1:0]  ATT_STEP_RST    = 4'd4;

    // state reset values
    localparam logic [ATT_W-1:0] ATT_VALUE_RST = 8'd64;
    localparam logic [3:0]       LEVELS_RST    = 4'hF;

    // track step codes
    typedef enum logic [1:0] {
        STEP_NONE = 2'd0,
        STEP_NEXT = 2'd1,
        STEP_PREV = 2'd2
    } track_step_t;

    // register index, word address bits [3:2]
    typedef enum logic [1:0] {
        REG_SAMPLE_RATE = 2'd0,
        REG_ATT_UPPER   = 2'd1,
        REG_ATT_LOWER   = 2'd2,
        REG_ATT_STEP    = 2'd3
    } reg_index_t;

    // configuration registers
    typedef struct packed {
        logic [SRATE_W-1:0] sample_rate;
        logic [ATT_W-1:0]   att_upper;
        logic [ATT_W-1:0]   att_lower;
        logic [STEP_W-1:0]  att_step;
    } pbc_cfg_t;

    // per-tick state besides the countdown
    typedef struct packed {
        logic [3:0]       prior_levels;
        logic             pause_flag;
        logic [ATT_W-1:0] attenuation;
        logic             hold_active;
        logic             short_click;
        logic             click_pending;
    } pbc_state_t;

endpackage

### rtl/pbc_regs.sv
// APB-style configuration register file for the player button controller.
// Depends on pbc_pkg.
module pbc_regs (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [pbc_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready,
    output pbc_pkg::pbc_cfg_t         cfg
);
    import pbc_pkg::*;

    pbc_cfg_t   cfg_reg;
    reg_index_t idx;
    logic       wr_en;

    assign pready = 1'b1;
    assign idx    = reg_index_t'(paddr[3:2]);
    assign wr_en  = psel && penable && pwrite && pready;
    assign cfg    = cfg_reg;

    // register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.sample_rate <= SAMPLE_RATE_RST;
            cfg_reg.att_upper   <= ATT_UPPER_RST;
            cfg_reg.att_lower   <= ATT_LOWER_RST;
            cfg_reg.att_step    <= ATT_STEP_RST;
        end else if (wr_en) begin
            case (idx)
                REG_SAMPLE_RATE: cfg_reg.sample_rate <= pwdata[SRATE_W-1:0];
                REG_ATT_UPPER:   cfg_reg.att_upper   <= pwdata[ATT_W-1:0];
                REG_ATT_LOWER:   cfg_reg.att_lower   <= pwdata[ATT_W-1:0];
                REG_ATT_STEP:    cfg_reg.att_step    <= pwdata[STEP_W-1:0];
                default: ;
            endcase
        end
    end

    // read mux
    always_comb begin
        prdata = '0;
        case (idx)
            REG_SAMPLE_RATE: prdata = {{(32-SRATE_W){1'b0}}, cfg_reg.sample_rate};
            REG_ATT_UPPER:   prdata = {{(32-ATT_W){1'b0}}, cfg_reg.att_upper};
            REG_ATT_LOWER:   prdata = {{(32-ATT_W){1'b0}}, cfg_reg.att_lower};
            REG_ATT_STEP:    prdata = {{(32-STEP_W){1'b0}}, cfg_reg.att_step};
            default:         prdata = '0;
        endcase
    end

endmodule

### rtl/pbc_step.sv
// Per-tick update logic: edge detection, pause toggling, volume hold repeat
// and short-click handling. Purely combinational. Depends on pbc_pkg.
module pbc_step #(
    parameter int COUNT_BITS = pbc_pkg::COUNT_BITS_DEF
) (
    input  pbc_pkg::pbc_cfg_t                  cfg,
    input  pbc_pkg::pbc_state_t                st,
    input  logic [COUNT_BITS-1:0]              count,
    input  logic [3:0]                         levels,
    input  logic [pbc_pkg::ELAPSED_W-1:0]      elapsed,
    output pbc_pkg::pbc_state_t                st_next,
    output logic [COUNT_BITS-1:0]              count_next,
    output pbc_pkg::track_step_t               track_step,
    output logic                               cancel_play
);
    import pbc_pkg::*;

    logic [3:0]            press;
    logic [COUNT_BITS-1:0] reload;
    logic [COUNT_BITS-1:0] elapsed_ext;
    logic                  vol_release;
    logic                  pause_f;
    logic [ATT_W-1:0]      att;
    logic [ATT_W:0]        att_sum;
    logic [ATT_W-1:0]      step_ext;
    logic [COUNT_BITS-1:0] cnt;
    logic                  ha;
    logic                  scp;
    logic                  cp;

    // level order: next, pause, prev, volume
    assign press       = ~levels & st.prior_levels;
    assign vol_release = levels[3] & ~st.prior_levels[3];
    assign reload      = {{(COUNT_BITS-RELOAD_W){1'b0}}, cfg.sample_rate[SRATE_W-1:1]};
    assign elapsed_ext = {{(COUNT_BITS-ELAPSED_W){1'b0}}, elapsed};
    assign step_ext    = {{(ATT_W-STEP_W){1'b0}}, cfg.att_step};

    always_comb begin
        // track buttons and pause, previous applied last
        track_step  = STEP_NONE;
        cancel_play = 1'b0;
        pause_f     = st.pause_flag;
        if (press[0]) begin
            track_step  = STEP_NEXT;
            cancel_play = 1'b1;
            pause_f     = 1'b0;
        end
        if (press[1]) begin
            pause_f = ~pause_f;
        end
        if (press[2]) begin
            track_step  = STEP_PREV;
            cancel_play = 1'b1;
            pause_f     = 1'b0;
        end

        // volume press and release
        cnt = count;
        ha  = st.hold_active;
        scp = st.short_click;
        cp  = st.click_pending;
        att = st.attenuation;
        att_sum = '0;
        if (press[3]) begin
            cnt = reload;
            ha  = 1'b1;
            scp = 1'b1;
            cp  = 1'b1;
        end else if (vol_release) begin
            cnt = '0;
            ha  = 1'b0;
        end

        // hold countdown and repeat raise
        if (ha) begin
            if (cnt != '0) begin
                cnt = (cnt > elapsed_ext) ? (cnt - elapsed_ext) : '0;
            end else begin
                scp = 1'b0;
                cnt = reload;
                if (att < cfg.att_upper) begin
                    att_sum = {1'b0, att} + {1'b0, step_ext};
                    att     = att_sum[ATT_W] ? {ATT_W{1'b1}} : att_sum[ATT_W-1:0];
                end
            end
        end

        // short click lowers once
        if (!ha && scp && cp) begin
            cp = 1'b0;
            if (att > cfg.att_lower) begin
                att = (att > step_ext) ? (att - step_ext) : '0;
            end
        end

        st_next.prior_levels  = levels;
        st_next.pause_flag    = pause_f;
        st_next.attenuation   = att;
        st_next.hold_active   = ha;
        st_next.short_click   = scp;
        st_next.click_pending = cp;
        count_next            = cnt;
    end

endmodule

### rtl/player_button_controller_top.sv
// Top level of the player button controller: input word register, state and
// result register around the step logic, plus the APB register file.
// Depends on pbc_pkg, pbc_regs and pbc_step.

// One tick word is taken per clock cycle while s_tready is high. The word is
// first captured in an input register. The step logic then updates the button
// state and loads the result register when that register is free or draining.
// A waiting result does not stop intake as long as the input register can
// move on, so the block holds at most two words. Throughput is one word per
// cycle while m_tready is high. The hold countdown is COUNT_BITS wide.
// Configuration registers are written through the APB port; the user must
// write them only while no word is in flight, the block itself does not enforce this.
module player_button_controller_top #(
    parameter int COUNT_BITS = pbc_pkg::COUNT_BITS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    // s_tdata: next_level[0], pause_level[1], prev_level[2], volume_level[3],
    //          elapsed_samples[15:4]
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [pbc_pkg::S_DATA_W-1:0] s_tdata,
    // m_tdata: track_step[1:0], cancel_play[2], paused[3], attenuation[11:4],
    //          zero[15:12]
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [pbc_pkg::M_DATA_W-1:0] m_tdata,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [pbc_pkg::ADDR_W-1:0]   paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);
    import pbc_pkg::*;

    pbc_cfg_t              cfg;
    logic                  in_valid_reg;
    logic [S_DATA_W-1:0]   in_data_reg;
    logic                  out_valid_reg;
    logic [M_DATA_W-1:0]   out_data_reg;
    pbc_state_t            st_reg;
    pbc_state_t            st_next;
    logic [COUNT_BITS-1:0] count_reg;
    logic [COUNT_BITS-1:0] count_next;
    track_step_t           track_step;
    logic                  cancel_play;
    logic                  fire;

    pbc_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    pbc_step #(
        .COUNT_BITS (COUNT_BITS)
    ) u_step (
        .cfg         (cfg),
        .st          (st_reg),
        .count       (count_reg),
        .levels      (in_data_reg[3:0]),
        .elapsed     (in_data_reg[4 +: ELAPSED_W]),
        .st_next     (st_next),
        .count_next  (count_next),
        .track_step  (track_step),
        .cancel_play (cancel_play)
    );

    // handshake: step fires when the result register is free or draining
    assign fire     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || fire;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // input word register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_data_reg <= s_tdata;
        end
    end

    // button state and countdown
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg.prior_levels  <= LEVELS_RST;
            st_reg.pause_flag    <= 1'b0;
            st_reg.attenuation   <= ATT_VALUE_RST;
            st_reg.hold_active   <= 1'b0;
            st_reg.short_click   <= 1'b0;
            st_reg.click_pending <= 1'b0;
            count_reg            <= '0;
        end else if (fire) begin
            st_reg    <= st_next;
            count_reg <= count_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (fire) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            out_data_reg <= {4'b0000, st_next.attenuation, st_next.pause_flag,
                             cancel_play, track_step};
        end
    end

endmodule

### rtl/pbc_checker.sv
// Port-level checks on the result channel of the player button controller,
// bound to the top level. Depends on player_button_controller_top.
module pbc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);

    // no result word right after reset
    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result word valid after reset");

    // track step code 3 means nothing
    a_step_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[1:0] != 2'd3)
        else $error("illegal track step code");

    // cancel goes with a track step and only with one
    a_cancel_step: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[2] == (m_tdata[1:0] != 2'd0)))
        else $error("cancel and track step disagree");

    // a stalled result word holds
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

endmodule

bind player_button_controller_top pbc_checker u_pbc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

### verif/player_button_controller_top_tb.sv
// Self-checking testbench for player_button_controller_top: tick words in, status words out.
// Drives the stream and APB ports and predicts every status word in a scoreboard class.
// Depends on pbc_pkg and the player_button_controller_top RTL.
`timescale 1ns / 100ps

module player_button_controller_top_tb;
    import pbc_pkg::*;

    // button level patterns, bit 0 next, 1 pause, 2 prev, 3 volume, 0 = pressed
    localparam logic [3:0] ALL_UP   = 4'hF;
    localparam logic [3:0] NEXT_DN  = 4'hE;
    localparam logic [3:0] PAUSE_DN = 4'hD;
    localparam logic [3:0] PREV_DN  = 4'hB;
    localparam logic [3:0] VOL_DN   = 4'h7;
    localparam int MAX_PRINTED = 40;

    // one expected status word
    typedef struct {
        track_step_t      step;
        logic             cancel;
        logic             paused;
        logic [ATT_W-1:0] att;
    } status_t;

    // predicts the status word of each accepted tick and checks the results
    class button_tick_scoreboard;
        logic [SRATE_W-1:0]        sample_rate;
        logic [ATT_W-1:0]          att_upper;
        logic [ATT_W-1:0]          att_lower;
        logic [STEP_W-1:0]         att_step;
        logic [3:0]                prior_levels;
        logic                      pause_flag;
        logic [ATT_W-1:0]          attenuation;
        logic [COUNT_BITS_DEF-1:0] countdown;
        logic                      hold_active;
        logic                      short_click;
        logic                      click_pending;
        status_t                   expected_status[$];
        int                        mismatches;
        int                        checked;

        function new();
            sample_rate   = SAMPLE_RATE_RST;
            att_upper     = ATT_UPPER_RST;
            att_lower     = ATT_LOWER_RST;
            att_step      = ATT_STEP_RST;
            prior_levels  = LEVELS_RST;
            pause_flag    = 1'b0;
            attenuation   = ATT_VALUE_RST;
            countdown     = '0;
            hold_active   = 1'b0;
            short_click   = 1'b0;
            click_pending = 1'b0;
            mismatches    = 0;
            checked       = 0;
        endfunction

        function int pending();
            return expected_status.size();
        endfunction

        function void write_reg(reg_index_t idx, logic [31:0] value);
            case (idx)
                REG_SAMPLE_RATE: sample_rate = value[SRATE_W-1:0];
                REG_ATT_UPPER:   att_upper   = value[ATT_W-1:0];
                REG_ATT_LOWER:   att_lower   = value[ATT_W-1:0];
                REG_ATT_STEP:    att_step    = value[STEP_W-1:0];
                default: ;
            endcase
        endfunction

        // advance the button state by one tick
        function void note_tick(logic [S_DATA_W-1:0] word);
            logic [3:0]                lv;
            logic [ELAPSED_W-1:0]      elapsed;
            logic [COUNT_BITS_DEF-1:0] elapsed_ext;
            logic [COUNT_BITS_DEF-1:0] reload;
            logic [ATT_W-1:0]          step_ext;
            logic [ATT_W:0]            sum;
            status_t                   st;
            lv          = word[3:0];
            elapsed     = word[ELAPSED_W+3:4];
            elapsed_ext = {{(COUNT_BITS_DEF-ELAPSED_W){1'b0}}, elapsed};
            reload      = {{(COUNT_BITS_DEF-SRATE_W+1){1'b0}}, sample_rate[SRATE_W-1:1]};
            step_ext    = {{(ATT_W-STEP_W){1'b0}}, att_step};
            st.step   = STEP_NONE;
            st.cancel = 1'b0;

            // track and pause presses, in the order next, pause, prev
            if (!lv[0] && prior_levels[0]) begin
                st.step    = STEP_NEXT;
                st.cancel  = 1'b1;
                pause_flag = 1'b0;
            end
            if (!lv[1] && prior_levels[1])
                pause_flag = !pause_flag;
            if (!lv[2] && prior_levels[2]) begin
                st.step    = STEP_PREV;
                st.cancel  = 1'b1;
                pause_flag = 1'b0;
            end

            // volume press and release
            if (!lv[3] && prior_levels[3]) begin
                countdown     = reload;
                hold_active   = 1'b1;
                short_click   = 1'b1;
                click_pending = 1'b1;
            end else if (lv[3] && !prior_levels[3]) begin
                countdown   = '0;
                hold_active = 1'b0;
            end

            // hold repeat raises attenuation on each expiry
            if (hold_active) begin
                if (countdown != '0) begin
                    countdown = (countdown > elapsed_ext) ? countdown - elapsed_ext : '0;
                end else begin
                    short_click = 1'b0;
                    countdown   = reload;
                    if (attenuation < att_upper) begin
                        sum         = {1'b0, attenuation} + {1'b0, step_ext};
                        attenuation = sum[ATT_W] ? 8'hFF : sum[ATT_W-1:0];
                    end
                end
            end

            // short click lowers attenuation once
            if (!hold_active && short_click && click_pending) begin
                click_pending = 1'b0;
                if (attenuation > att_lower)
                    attenuation = (attenuation > step_ext) ? attenuation - step_ext : '0;
            end

            prior_levels = lv;
            st.paused    = pause_flag;
            st.att       = attenuation;
            expected_status.push_back(st);
        endfunction

        task report(string msg);
            mismatches++;
            if (mismatches <= MAX_PRINTED)
                $display("%0t ns: error: %s", $time, msg);
        endtask

        // compare a status word with the oldest prediction
        task check_status(logic [M_DATA_W-1:0] word);
            status_t exp;
            if (expected_status.size() == 0) begin
                report($sformatf("status word %h with no tick waiting", word));
                return;
            end
            exp = expected_status.pop_front();
            checked++;
            if (word[1:0] !== exp.step)
                report($sformatf("track step %0d, expected %s", word[1:0], exp.step.name()));
            if (word[2] !== exp.cancel)
                report($sformatf("cancel %b, expected %b", word[2], exp.cancel));
            if (word[3] !== exp.paused)
                report($sformatf("paused %b, expected %b", word[3], exp.paused));
            if (word[11:4] !== exp.att)
                report($sformatf("attenuation %0d, expected %0d", word[11:4], exp.att));
            if (word[15:12] !== 4'h0)
                report($sformatf("padding bits %b, expected zero", word[15:12]));
        endtask
    endclass

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_DATA_W-1:0]   m_tdata;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [ADDR_W-1:0]     paddr;
    logic [31:0]           pwdata;
    logic [31:0]           prdata;
    logic                  pready;

    button_tick_scoreboard scoreboard = new();
    int tx_idle_pct      = 0;
    int rx_idle_pct      = 0;
    int rx_hold_off      = 0;
    int ticks_sent       = 0;
    int settings_applied = 0;

    player_button_controller_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // 10 ns clock
    initial aclk = 1'b0;
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // hard limit on run time
    initial begin
        #4_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // receiver: random stalls, plus a long hold-off on request
    initial begin
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (rx_hold_off > 0) begin
                m_tready <= 1'b0;
                rx_hold_off--;
            end else begin
                m_tready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // status word monitor
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            scoreboard.check_status(m_tdata);
    end

    // offer one tick word and wait for it to be taken
    task automatic send_tick(input logic [3:0] levels, input logic [ELAPSED_W-1:0] elapsed);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {elapsed, levels};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        scoreboard.note_tick({elapsed, levels});
        ticks_sent++;
    endtask

    // apb write: setup cycle then access cycle
    task automatic write_reg(input reg_index_t idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready)
            @(posedge aclk);
        scoreboard.write_reg(idx, value);
    endtask

    // drain the block, then load all four registers
    task automatic apply_setting(input int rate, input int upper, input int lower,
                                 input int step);
        s_tvalid <= 1'b0;
        while (scoreboard.pending() != 0)
            @(posedge aclk);
        write_reg(REG_SAMPLE_RATE, rate);
        write_reg(REG_ATT_UPPER, upper);
        write_reg(REG_ATT_LOWER, lower);
        write_reg(REG_ATT_STEP, step);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        settings_applied++;
    endtask

    // one random user action: click, hold, track/pause press or noise
    task automatic play_gesture();
        int kind;
        int n;
        kind = $urandom_range(99);
        if (kind < 35) begin
            // short volume click
            send_tick(VOL_DN, ELAPSED_W'($urandom_range(0, 300)));
            n = $urandom_range(0, 1);
            repeat (n) send_tick(VOL_DN, ELAPSED_W'($urandom_range(0, 300)));
            send_tick(ALL_UP, ELAPSED_W'($urandom_range(0, 4095)));
        end else if (kind < 50) begin
            // volume hold, occasionally a long one
            n = $urandom_range(1, 12);
            if ($urandom_range(9) == 0)
                n = $urandom_range(20, 40);
            send_tick(VOL_DN, ELAPSED_W'($urandom_range(0, 4095)));
            repeat (n) send_tick(VOL_DN, ELAPSED_W'($urandom_range(0, 4095)));
            send_tick(ALL_UP, ELAPSED_W'($urandom_range(0, 4095)));
        end else if (kind < 85) begin
            // any mix of next, pause and prev
            n = $urandom_range(1, 3);
            kind = $urandom_range(1, 7);
            repeat (n) send_tick({1'b1, ~kind[2:0]}, ELAPSED_W'($urandom_range(0, 4095)));
            send_tick(ALL_UP, ELAPSED_W'($urandom_range(0, 4095)));
        end else begin
            // level noise
            n = $urandom_range(1, 4);
            repeat (n) send_tick(4'($urandom_range(0, 15)),
                                 ELAPSED_W'($urandom_range(0, 4095)));
        end
    endtask

    task automatic run_gestures(input int count);
        int start;
        start = ticks_sent;
        while (ticks_sent - start < count)
            play_gesture();
    endtask

    // main sequence
    initial begin
        int guard;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        aresetn  <= 1'b0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // directed part at reset settings
        tx_idle_pct = 9;
        rx_idle_pct = 71;
        send_tick(ALL_UP, 0);
        send_tick(NEXT_DN, 4095);
        send_tick(ALL_UP, 12);
        send_tick(PAUSE_DN, 1);
        send_tick(ALL_UP, 0);
        // next with pause leaves the flag set
        send_tick(NEXT_DN & PAUSE_DN, 7);
        send_tick(ALL_UP, 0);
        // prev with pause leaves it clear
        send_tick(PREV_DN & PAUSE_DN, 2048);
        send_tick(ALL_UP, 0);
        // prev wins over next
        send_tick(NEXT_DN & PREV_DN, 4095);
        send_tick(ALL_UP, 0);
        // short click, then a hold that expires once
        send_tick(VOL_DN, 0);
        send_tick(ALL_UP, 0);
        repeat (8) send_tick(VOL_DN, 4095);
        send_tick(ALL_UP, 4095);

        // zero reload: every held tick expires, attenuation saturates high
        apply_setting(0, 255, 0, 15);
        repeat (14) send_tick(VOL_DN, 0);
        send_tick(ALL_UP, 0);

        // sender sparse idling, receiver heavy stalls
        apply_setting(8000, 255, 0, 15);
        run_gestures(300);
        apply_setting(96000, 200, 10, 7);
        run_gestures(300);

        // swapped idling, zero step and widest reload
        tx_idle_pct = 71;
        rx_idle_pct = 9;
        apply_setting(131071, 0, 255, 0);
        run_gestures(300);
        apply_setting(20000, 128, 64, 3);
        run_gestures(300);

        // no idling; long receiver hold-off to back up the input
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        apply_setting(1, 255, 0, 15);
        rx_hold_off = 400;
        run_gestures(300);
        apply_setting(44100, 96, 3, 4);
        run_gestures(300);

        // wait for the last status words
        s_tvalid <= 1'b0;
        guard = 0;
        while (scoreboard.pending() != 0 && guard < 20000) begin
            @(posedge aclk);
            guard++;
        end
        repeat (4) @(posedge aclk);
        if (scoreboard.pending() != 0)
            scoreboard.report($sformatf("%0d status words never arrived",
                                        scoreboard.pending()));

        $display("%0d tick words over %0d register settings, %0d status words checked",
                 ticks_sent, settings_applied, scoreboard.checked);
        $display("covered track steps, pause toggles, volume clicks and hold repeats");
        if (scoreboard.mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
